FILE: hw/rtl/timed_voice_channel_allocator_macros.svh
// Assertion macros shared by the voice channel allocator RTL.
`ifndef TIMED_VOICE_CHANNEL_ALLOCATOR_MACROS_SVH
`define TIMED_VOICE_CHANNEL_ALLOCATOR_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define TVA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define TVA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/tva_pkg.sv
// Shared constants and request codes for the voice channel allocator.
`default_nettype none

package tva_pkg;

	localparam int NUM_CHANNELS_DEF = 8;

	localparam int KIND_W  = 2;
	localparam int TIME_W  = 32;
	localparam int TAG_W   = 8;
	localparam int FREQ_W  = 16;
	localparam int RATIO_W = 16;
	localparam int ASG_W   = 3;
	localparam int MASK_W  = 8;

	localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ADV   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REL   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

endpackage

`default_nettype wire

FILE: hw/rtl/timed_voice_channel_allocator.sv
// Voice channel allocator: channel table, scan sequencer and result register.
//
// Usage: requests enter on the in_valid/in_ready channel (kind, now_time,
// start_time, duration, logical_channel, frequency, ratio); one result per
// request leaves on out_valid/out_ready (success, assigned_channel,
// released_mask, next_stop_time, next_stop_valid).
// Each request is handled by a sequencer that walks the channel table one
// channel per cycle with a single shared 32-bit less-than comparator: a first
// pass applies the request (expiry, allocation, release by tag or clear), a
// second pass finds the earliest stop time among the busy channels.
// The result is registered once both table passes are done. in_ready is
// high only while the sequencer is idle, so a new request is taken only
// after the previous one has finished both passes and its result has been
// loaded into the result register.
// The result register frees the sequencer from the receiver: a stalled
// result is held until taken, and a finished scan waits in its final state
// only while the previous result is still pending.
// Reset (arst_n low) frees every channel, zeroes the table, and drops any
// request in flight and any pending result.
`default_nettype none

`include "timed_voice_channel_allocator_macros.svh"

module timed_voice_channel_allocator
	import tva_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [KIND_W-1:0]   kind,
	input  wire logic [TIME_W-1:0]   now_time,
	input  wire logic [TIME_W-1:0]   start_time,
	input  wire logic [TIME_W-1:0]   duration,
	input  wire logic [TAG_W-1:0]    logical_channel,
	input  wire logic [FREQ_W-1:0]   frequency,
	input  wire logic [RATIO_W-1:0]  ratio,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     success,
	output logic [ASG_W-1:0]         assigned_channel,
	output logic [MASK_W-1:0]        released_mask,
	output logic [TIME_W-1:0]        next_stop_time,
	output logic                     next_stop_valid
);

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_CHANNELS - 1);

	localparam int ST_W = 2;
	localparam logic [ST_W-1:0] ST_IDLE = 2'd0;
	localparam logic [ST_W-1:0] ST_UPD  = 2'd1;
	localparam logic [ST_W-1:0] ST_MIN  = 2'd2;
	localparam logic [ST_W-1:0] ST_OUT  = 2'd3;

	// channel table
	logic [NUM_CHANNELS-1:0] busy_q;
	logic [TAG_W-1:0]        tag_q   [NUM_CHANNELS];
	logic [TIME_W-1:0]       stop_q  [NUM_CHANNELS];
	logic [FREQ_W-1:0]       freq_q  [NUM_CHANNELS];
	logic [RATIO_W-1:0]      ratio_q [NUM_CHANNELS];

	// sequencer and request registers
	logic [ST_W-1:0]    state_q;
	logic [IDX_W-1:0]   idx_q;
	logic [KIND_W-1:0]  kind_q;
	logic [TIME_W-1:0]  now_q;
	logic [TIME_W-1:0]  new_stop_q;
	logic [TAG_W-1:0]   req_tag_q;
	logic [FREQ_W-1:0]  req_freq_q;
	logic [RATIO_W-1:0] req_ratio_q;

	// accumulators
	logic [NUM_CHANNELS-1:0] mask_acc_q;
	logic                    ok_q;
	logic                    found_q;
	logic [IDX_W-1:0]        asg_q;
	logic [TIME_W-1:0]       earliest_q;
	logic                    early_vld_q;

	// result register
	logic               out_valid_q;
	logic               success_q;
	logic [ASG_W-1:0]   assigned_q;
	logic [MASK_W-1:0]  released_q;
	logic [TIME_W-1:0]  next_stop_q;
	logic               next_vld_q;

	logic                accept;
	logic                idx_last;
	logic                load_out;
	logic [TIME_W:0]     stop_sum;
	logic [TIME_W-1:0]   stop_sat;
	logic [TIME_W-1:0]   cmp_a;
	logic [TIME_W-1:0]   cmp_b;
	logic                cmp_lt;
	logic                cur_busy;
	logic                rel_hit;
	logic                take_hit;
	logic                min_hit;
	logic [NUM_CHANNELS+MASK_W-1:0] mask_wide;
	logic [IDX_W+ASG_W-1:0]         asg_wide;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign idx_last = (idx_q == IDX_LAST);
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// stop time of a new note, saturated at the top of the time range
	assign stop_sum = {1'b0, start_time} + {1'b0, duration};
	assign stop_sat = stop_sum[TIME_W] ? {TIME_W{1'b1}} : stop_sum[TIME_W-1:0];

	assign cur_busy = busy_q[idx_q];

	// shared comparator: expiry test in the update pass, minimum in the second
	always_comb begin
		if (state_q == ST_MIN) begin
			cmp_a = stop_q[idx_q];
			cmp_b = earliest_q;
		end else begin
			cmp_a = now_q;
			cmp_b = stop_q[idx_q];
		end
	end
	assign cmp_lt = (cmp_a < cmp_b);

	always_comb begin
		rel_hit  = 1'b0;
		take_hit = 1'b0;
		if (state_q == ST_UPD) begin
			case (kind_q)
				KIND_ADD: begin
					rel_hit  = cur_busy && !cmp_lt;
					take_hit = (!cur_busy || !cmp_lt) && !found_q;
				end
				KIND_ADV: begin
					rel_hit = cur_busy && !cmp_lt;
				end
				KIND_REL: begin
					rel_hit = cur_busy && (tag_q[idx_q] == req_tag_q);
				end
				default: begin
					rel_hit = cur_busy;
				end
			endcase
		end
	end

	assign min_hit = (state_q == ST_MIN) && cur_busy && (!early_vld_q || cmp_lt);

	assign mask_wide = {{MASK_W{1'b0}}, mask_acc_q};
	assign asg_wide  = {{ASG_W{1'b0}}, asg_q};

	// table update, one channel per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				tag_q[i]   <= '0;
				stop_q[i]  <= '0;
				freq_q[i]  <= '0;
				ratio_q[i] <= '0;
			end
		end else if (state_q == ST_UPD) begin
			if (rel_hit) begin
				busy_q[idx_q] <= 1'b0;
				tag_q[idx_q]  <= '0;
			end
			if (kind_q == KIND_CLEAR) begin
				busy_q[idx_q]  <= 1'b0;
				tag_q[idx_q]   <= '0;
				freq_q[idx_q]  <= '0;
				ratio_q[idx_q] <= '0;
			end
			// a free or just-expired channel takes the note
			if (take_hit) begin
				busy_q[idx_q]  <= 1'b1;
				tag_q[idx_q]   <= req_tag_q;
				stop_q[idx_q]  <= new_stop_q;
				freq_q[idx_q]  <= req_freq_q;
				ratio_q[idx_q] <= req_ratio_q;
			end
		end
	end

	// request capture; needs no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q      <= kind;
			now_q       <= now_time;
			new_stop_q  <= stop_sat;
			req_tag_q   <= logical_channel;
			req_freq_q  <= frequency;
			req_ratio_q <= ratio;
		end
	end

	// sequencer and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			mask_acc_q  <= '0;
			ok_q        <= 1'b0;
			found_q     <= 1'b0;
			asg_q       <= '0;
			earliest_q  <= '0;
			early_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q     <= ST_UPD;
						idx_q       <= '0;
						mask_acc_q  <= '0;
						ok_q        <= (kind == KIND_ADV) || (kind == KIND_CLEAR);
						found_q     <= 1'b0;
						asg_q       <= '0;
						earliest_q  <= '0;
						early_vld_q <= 1'b0;
					end
				end
				ST_UPD: begin
					if (rel_hit) begin
						mask_acc_q[idx_q] <= 1'b1;
						if (kind_q == KIND_REL) begin
							ok_q <= 1'b1;
						end
					end
					if (take_hit) begin
						found_q <= 1'b1;
						ok_q    <= 1'b1;
						asg_q   <= idx_q;
					end
					if (idx_last) begin
						idx_q   <= '0;
						state_q <= ST_MIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_MIN: begin
					if (min_hit) begin
						earliest_q  <= stop_q[idx_q];
						early_vld_q <= 1'b1;
					end
					if (idx_last) begin
						idx_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_OUT: begin
					// hold until the result register is free
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			success_q   <= ok_q;
			assigned_q  <= asg_wide[ASG_W-1:0];
			released_q  <= mask_wide[MASK_W-1:0];
			next_stop_q <= earliest_q;
			next_vld_q  <= early_vld_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign success          = success_q;
	assign assigned_channel = assigned_q;
	assign released_mask    = released_q;
	assign next_stop_time   = next_stop_q;
	assign next_stop_valid  = next_vld_q;

	`TVA_ASSERT_NEXT(a_accept_starts_scan, accept, state_q == ST_UPD,
		"accepted item did not start the update pass")
	`TVA_ASSERT(a_idle_idx_zero, (state_q != ST_IDLE) || (idx_q == '0),
		"scan index not parked at zero while idle")
	`TVA_ASSERT(a_alloc_busy, (state_q != ST_MIN) || !found_q || busy_q[asg_q],
		"allocated channel is not busy after the update pass")
	`TVA_ASSERT(a_no_busy_zero_time, !out_valid || next_stop_valid || (next_stop_time == '0),
		"next stop time not zero with no busy channel")
	`TVA_ASSERT_NEXT(a_load_sets_valid, load_out, out_valid_q && (state_q == ST_IDLE),
		"result load did not raise out_valid and return to idle")

endmodule

`default_nettype wire

FILE: tb/voice_alloc_checker.sv
`timescale 1ns / 1ps
// Result checker for the voice channel allocator: predicts every result and compares it.
module voice_alloc_checker
	import tva_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [KIND_W-1:0]  kind,
	input  logic [TIME_W-1:0]  now_time,
	input  logic [TIME_W-1:0]  start_time,
	input  logic [TIME_W-1:0]  duration,
	input  logic [TAG_W-1:0]   logical_channel,
	input  logic [FREQ_W-1:0]  frequency,
	input  logic [RATIO_W-1:0] ratio,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               success,
	input  logic [ASG_W-1:0]   assigned_channel,
	input  logic [MASK_W-1:0]  released_mask,
	input  logic [TIME_W-1:0]  next_stop_time,
	input  logic               next_stop_valid,
	output int                 fault_count,
	output int                 pending,
	output int                 result_count
);

	localparam int NCH = NUM_CHANNELS_DEF;

	typedef struct packed {
		logic               ok;
		logic [ASG_W-1:0]   channel;
		logic [MASK_W-1:0]  freed;
		logic [TIME_W-1:0]  earliest;
		logic               earliest_valid;
	} voice_result_t;

	logic               voice_busy  [NCH];
	logic [TAG_W-1:0]   voice_tag   [NCH];
	logic [TIME_W-1:0]  voice_stop  [NCH];
	logic [FREQ_W-1:0]  voice_freq  [NCH];
	logic [RATIO_W-1:0] voice_ratio [NCH];

	voice_result_t expected_results[$];
	voice_result_t oldest;

	initial begin
		fault_count = 0;
		pending = 0;
		result_count = 0;
	end

	// Free every busy voice whose stop time has come.
	function automatic logic [MASK_W-1:0] expire_voices(input logic [TIME_W-1:0] t_now);
		logic [MASK_W-1:0] m;
		m = '0;
		for (int i = 0; i < NCH; i++) begin
			if (voice_busy[i] && voice_stop[i] <= t_now) begin
				voice_busy[i] = 1'b0;
				voice_tag[i] = '0;
				m[i] = 1'b1;
			end
		end
		return m;
	endfunction

	function automatic voice_result_t allocate_voice(
		input logic [KIND_W-1:0]  k,
		input logic [TIME_W-1:0]  t_now,
		input logic [TIME_W-1:0]  t_start,
		input logic [TIME_W-1:0]  t_len,
		input logic [TAG_W-1:0]   tag,
		input logic [FREQ_W-1:0]  freq,
		input logic [RATIO_W-1:0] rat
	);
		voice_result_t r;
		logic [TIME_W:0] stop_sum;
		r = '0;
		r.ok = 1'b1;
		stop_sum = {1'b0, t_start} + {1'b0, t_len};
		case (k)
			KIND_ADD: begin
				r.freed = expire_voices(t_now);
				r.ok = 1'b0;
				for (int i = 0; i < NCH; i++) begin
					if (!r.ok && !voice_busy[i]) begin
						voice_busy[i] = 1'b1;
						voice_tag[i] = tag;
						voice_freq[i] = freq;
						voice_ratio[i] = rat;
						// saturate at the top of the time range
						voice_stop[i] = stop_sum[TIME_W] ? '1 : stop_sum[TIME_W-1:0];
						r.ok = 1'b1;
						r.channel = ASG_W'(i);
					end
				end
			end
			KIND_ADV: r.freed = expire_voices(t_now);
			KIND_REL: begin
				r.ok = 1'b0;
				for (int i = 0; i < NCH; i++) begin
					if (voice_busy[i] && voice_tag[i] == tag) begin
						voice_busy[i] = 1'b0;
						voice_tag[i] = '0;
						r.freed[i] = 1'b1;
						r.ok = 1'b1;
					end
				end
			end
			default: begin
				// stop times survive a clear
				for (int i = 0; i < NCH; i++) begin
					r.freed[i] = voice_busy[i];
					voice_busy[i] = 1'b0;
					voice_tag[i] = '0;
					voice_freq[i] = '0;
					voice_ratio[i] = '0;
				end
			end
		endcase
		for (int i = 0; i < NCH; i++) begin
			if (voice_busy[i] && (!r.earliest_valid || voice_stop[i] < r.earliest)) begin
				r.earliest = voice_stop[i];
				r.earliest_valid = 1'b1;
			end
		end
		return r;
	endfunction

	task automatic check_field(input string what, input logic [TIME_W-1:0] want,
			input logic [TIME_W-1:0] got);
		if (want !== got) begin
			fault_count++;
			if (fault_count <= 10)
				$display("%0t: result %0d, %s: expected %0h, got %0h",
					$realtime, result_count, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				voice_busy[i] = 1'b0;
				voice_tag[i] = '0;
				voice_stop[i] = '0;
				voice_freq[i] = '0;
				voice_ratio[i] = '0;
			end
			expected_results.delete();
			pending = 0;
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(allocate_voice(kind, now_time, start_time, duration,
					logical_channel, frequency, ratio));
			if (out_valid && out_ready) begin
				result_count++;
				if (expected_results.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("%0t: result %0d arrived with nothing expected",
							$realtime, result_count);
				end else begin
					oldest = expected_results.pop_front();
					check_field("success", TIME_W'(oldest.ok), TIME_W'(success));
					check_field("assigned_channel", TIME_W'(oldest.channel),
						TIME_W'(assigned_channel));
					check_field("released_mask", TIME_W'(oldest.freed), TIME_W'(released_mask));
					check_field("next_stop_time", oldest.earliest, next_stop_time);
					check_field("next_stop_valid", TIME_W'(oldest.earliest_valid),
						TIME_W'(next_stop_valid));
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

FILE: tb/timed_voice_channel_allocator_tb.sv
`timescale 1ns / 1ps
// Testbench top for the voice channel allocator: clock, reset, request stimulus and verdict.
module timed_voice_channel_allocator_tb;
	import tva_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [KIND_W-1:0]  kind;
	logic [TIME_W-1:0]  now_time;
	logic [TIME_W-1:0]  start_time;
	logic [TIME_W-1:0]  duration;
	logic [TAG_W-1:0]   logical_channel;
	logic [FREQ_W-1:0]  frequency;
	logic [RATIO_W-1:0] ratio;
	logic               out_valid;
	logic               out_ready;
	logic               success;
	logic [ASG_W-1:0]   assigned_channel;
	logic [MASK_W-1:0]  released_mask;
	logic [TIME_W-1:0]  next_stop_time;
	logic               next_stop_valid;

	int  alloc_faults;
	int  alloc_pending;
	int  alloc_results;
	int  kind_count [4];
	logic no_idle;

	timed_voice_channel_allocator uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.now_time(now_time),
		.start_time(start_time),
		.duration(duration),
		.logical_channel(logical_channel),
		.frequency(frequency),
		.ratio(ratio),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.success(success),
		.assigned_channel(assigned_channel),
		.released_mask(released_mask),
		.next_stop_time(next_stop_time),
		.next_stop_valid(next_stop_valid)
	);

	voice_alloc_checker alloc_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.now_time(now_time),
		.start_time(start_time),
		.duration(duration),
		.logical_channel(logical_channel),
		.frequency(frequency),
		.ratio(ratio),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.success(success),
		.assigned_channel(assigned_channel),
		.released_mask(released_mask),
		.next_stop_time(next_stop_time),
		.next_stop_valid(next_stop_valid),
		.fault_count(alloc_faults),
		.pending(alloc_pending),
		.result_count(alloc_results)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= no_idle || ($urandom_range(0, 99) >= 18);
	end

	// Offer one item at a falling edge and hold it until accepted.
	task automatic send_request(
		input logic [KIND_W-1:0]  k,
		input logic [TIME_W-1:0]  t_now,
		input logic [TIME_W-1:0]  t_start,
		input logic [TIME_W-1:0]  t_len,
		input logic [TAG_W-1:0]   tag,
		input logic [FREQ_W-1:0]  freq,
		input logic [RATIO_W-1:0] rat
	);
		if (!no_idle) begin
			while ($urandom_range(0, 99) < 18) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid <= 1'b1;
		kind <= k;
		now_time <= t_now;
		start_time <= t_start;
		duration <= t_len;
		logical_channel <= tag;
		frequency <= freq;
		ratio <= rat;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		kind_count[k]++;
		@(negedge clk);
	endtask

	initial begin
		#5_000_000;
		$display("timeout after %0t", $realtime);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [TIME_W-1:0] song_pos;
		logic [TIME_W-1:0] st;
		logic [TIME_W-1:0] du;
		int roll;
		int pick;

		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		no_idle = 1'b0;
		kind = KIND_ADV;
		now_time = '0;
		start_time = '0;
		duration = '0;
		logical_channel = '0;
		frequency = '0;
		ratio = '0;
		for (int i = 0; i < 4; i++)
			kind_count[i] = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: fill the table, saturate stop times, overflow it, then drain
		send_request(KIND_ADV, 32'd0, 32'd0, 32'd0, 8'd0, 16'd0, 16'd0);
		send_request(KIND_ADD, 32'd10, 32'd100, 32'd50, 8'd1, 16'hFFFF, 16'h0000);
		send_request(KIND_ADD, 32'd10, 32'd100, 32'd50, 8'd1, 16'h0000, 16'hFFFF);
		send_request(KIND_ADD, 32'd10, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd2, 16'h1234, 16'h5678);
		send_request(KIND_ADD, 32'd10, 32'd2, 32'd3, 8'd3, 16'd1, 16'd1);
		send_request(KIND_ADD, 32'd10, 32'd40, 32'd20, 8'hFF, 16'hFFFF, 16'hFFFF);
		send_request(KIND_ADD, 32'd10, 32'h8000_0000, 32'h7FFF_FFFF, 8'd4, 16'd2, 16'd3);
		send_request(KIND_ADD, 32'd10, 32'hFFFF_FFF0, 32'h0000_0010, 8'd5, 16'd4, 16'd5);
		send_request(KIND_ADD, 32'd10, 32'd0, 32'hFFFF_FFFF, 8'd6, 16'd6, 16'd7);
		send_request(KIND_ADD, 32'd4, 32'd7, 32'd7, 8'd9, 16'd8, 16'd9);
		send_request(KIND_ADD, 32'd10, 32'd20, 32'd0, 8'd0, 16'hAAAA, 16'h5555);
		send_request(KIND_REL, 32'd0, 32'd0, 32'd0, 8'd1, 16'd0, 16'd0);
		send_request(KIND_REL, 32'd0, 32'd0, 32'd0, 8'd1, 16'd0, 16'd0);
		send_request(KIND_REL, 32'd0, 32'd0, 32'd0, 8'd0, 16'd0, 16'd0);
		send_request(KIND_REL, 32'd0, 32'd0, 32'd0, 8'd0, 16'd0, 16'd0);
		send_request(KIND_ADV, 32'hFFFF_FFFE, 32'd0, 32'd0, 8'd0, 16'd0, 16'd0);
		send_request(KIND_ADV, 32'hFFFF_FFFF, 32'd0, 32'd0, 8'd0, 16'd0, 16'd0);
		send_request(KIND_CLEAR, 32'd0, 32'd0, 32'd0, 8'd0, 16'd0, 16'd0);
		send_request(KIND_ADD, 32'hFFFF_FFFF, 32'd5, 32'd5, 8'hAA, 16'h0F0F, 16'hF0F0);
		send_request(KIND_ADD, 32'd0, 32'd1, 32'd0, 8'h55, 16'hF0F0, 16'h0F0F);
		send_request(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
			16'hFFFF, 16'hFFFF);
		send_request(KIND_REL, 32'd0, 32'd0, 32'd0, 8'hAA, 16'd0, 16'd0);
		send_request(KIND_ADV, 32'd0, 32'd0, 32'd0, 8'd0, 16'd0, 16'd0);

		// random: a running song position with notes, expiry, releases and the odd clear
		song_pos = $urandom_range(0, 1000);
		for (int n = 0; n < 1450; n++) begin
			no_idle <= (n >= 500 && n < 800);
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				send_request(KIND_W'($urandom), $urandom, $urandom, $urandom,
					TAG_W'($urandom), FREQ_W'($urandom), RATIO_W'($urandom));
			end else begin
				if (roll < 10)
					song_pos = 32'hFFFF_FFFF - $urandom_range(0, 3000);
				else if (roll < 11)
					song_pos = $urandom;
				// hold at the top rather than wrap
				if (song_pos > 32'hFFFF_FFFF - 40)
					song_pos = 32'hFFFF_FFFF;
				else
					song_pos = song_pos + $urandom_range(0, 40);
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					st = song_pos + $urandom_range(0, 20);
					if ($urandom_range(0, 9) == 0)
						st = st - $urandom_range(0, 100);
					du = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000)
						: $urandom_range(0, 120);
					if ($urandom_range(0, 49) == 0)
						du = $urandom;
					send_request(KIND_ADD, song_pos, st, du, TAG_W'($urandom_range(0, 3)),
						FREQ_W'($urandom), RATIO_W'($urandom));
				end else if (pick < 76) begin
					send_request(KIND_ADV, song_pos, $urandom, $urandom, TAG_W'($urandom),
						FREQ_W'($urandom), RATIO_W'($urandom));
				end else if (pick < 94) begin
					send_request(KIND_REL, $urandom, $urandom, $urandom,
						($urandom_range(0, 9) == 0) ? TAG_W'($urandom)
							: TAG_W'($urandom_range(0, 3)),
						FREQ_W'($urandom), RATIO_W'($urandom));
				end else begin
					send_request(KIND_CLEAR, $urandom, $urandom, $urandom, TAG_W'($urandom),
						FREQ_W'($urandom), RATIO_W'($urandom));
				end
			end
		end
		in_valid <= 1'b0;
		no_idle <= 1'b0;

		while (alloc_pending != 0)
			@(posedge clk);
		repeat (2 * NUM_CHANNELS_DEF + 4) @(posedge clk);

		$display("Sent %0d notes, %0d time advances, %0d tag releases and %0d clears.",
			kind_count[KIND_ADD], kind_count[KIND_ADV], kind_count[KIND_REL],
			kind_count[KIND_CLEAR]);
		$display("Compared %0d results: %0d field mismatches, %0d results missing.",
			alloc_results, alloc_faults, alloc_pending);
		if (alloc_faults == 0 && alloc_pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/tva_pkg.sv
hw/rtl/timed_voice_channel_allocator.sv
tb/voice_alloc_checker.sv
tb/timed_voice_channel_allocator_tb.sv
